// File: hw/rtl/itrt_pkg.sv
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared constants, types and helpers for the integer to radix text unit.
// ----------------------------------------------------------------------------
`default_nettype none

package itrt_pkg;

    localparam int VALUE_BITS = 32;
    localparam int RADIX_W    = 6;
    localparam int MIN_W      = 6;
    localparam int CHAR_W     = 7;
    localparam int DIGIT_W    = 6;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int IDX_W      = $clog2(VALUE_BITS);
    localparam int BIT_W      = $clog2(VALUE_BITS);
    localparam int SAT_W      = (CNT_W > MIN_W) ? CNT_W : MIN_W;

    localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(36);
    localparam logic [CHAR_W-1:0]  CHAR_QUESTION = CHAR_W'(63);
    localparam logic [CHAR_W-1:0]  CHAR_MINUS    = CHAR_W'(45);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  CHAR_LETTER_A = CHAR_W'(65);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAD,
        ST_DIVIDE,
        ST_HEAD,
        ST_PAD,
        ST_DIGIT
    } state_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_BAD,
        EMIT_SIGN,
        EMIT_PAD,
        EMIT_DIGIT
    } emit_t;

    typedef struct packed {
        logic  load;
        logic  div_step;
        emit_t emit_sel;
    } cmd_t;

    typedef struct packed {
        logic radix_ok;
        logic div_last;
        logic quot_zero;
        logic neg;
        logic pad_more;
        logic pad_more_next;
        logic last_digit;
    } status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        if (d < DIGIT_W'(10))
            digit_char = CHAR_ZERO + CHAR_W'(d);
        else
            digit_char = CHAR_LETTER_A + CHAR_W'(d - DIGIT_W'(10));
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/itrt_ctrl.sv
// ----------------------------------------------------------------------------
// itrt_ctrl
// Sequencer: divide loop, then sign, padding and digit emission; a '?' for a bad radix.
// ----------------------------------------------------------------------------
`default_nettype none

module itrt_ctrl
    import itrt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire status_t status,
    output cmd_t         cmd,
    output logic         busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = status.radix_ok ? ST_DIVIDE : ST_BAD;
            end
            ST_BAD:
                state_next = ST_IDLE;
            ST_DIVIDE:
            begin
                if (status.div_last && status.quot_zero)
                    state_next = ST_HEAD;
            end
            ST_HEAD:
                state_next = status.pad_more ? ST_PAD : ST_DIGIT;
            ST_PAD:
                state_next = status.pad_more_next ? ST_PAD : ST_DIGIT;
            ST_DIGIT:
            begin
                if (status.last_digit)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.emit_sel = EMIT_NONE;
        busy         = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_BAD:
                cmd.emit_sel = EMIT_BAD;
            ST_DIVIDE:
                cmd.div_step = 1'b1;
            ST_HEAD:
                cmd.emit_sel = status.neg ? EMIT_SIGN : EMIT_NONE;
            ST_PAD:
                cmd.emit_sel = EMIT_PAD;
            ST_DIGIT:
                cmd.emit_sel = EMIT_DIGIT;
            default:
                busy = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/itrt_datapath.sv
// ----------------------------------------------------------------------------
// itrt_datapath
// Bit-serial divider, digit stack, pad counter and character output register.
// ----------------------------------------------------------------------------
`default_nettype none

module itrt_datapath
    import itrt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic [RADIX_W-1:0]    radix,
    input  wire logic [MIN_W-1:0]      min_digits,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    output logic [CHAR_W-1:0]          char_code,
    output logic                       last,
    output logic                       strobe
);

    logic [VALUE_BITS-1:0] mag_reg;
    logic [VALUE_BITS-1:0] mag_next;
    logic [DIGIT_W-1:0]    rem_reg;
    logic [DIGIT_W-1:0]    rem_next;
    logic [BIT_W-1:0]      bit_reg;
    logic [RADIX_W-1:0]    radix_reg;
    logic                  neg_reg;
    logic [CNT_W-1:0]      ndig_reg;
    logic [CNT_W-1:0]      pad_reg;
    logic [DIGIT_W-1:0]    stack_reg [VALUE_BITS];
    logic [CHAR_W-1:0]     char_reg;
    logic                  last_reg;
    logic                  strobe_reg;

    logic [DIGIT_W:0]      trial;
    logic                  qbit;
    logic [CNT_W-1:0]      ndig_dec;
    logic [SAT_W-1:0]      min_ext;
    logic [CNT_W-1:0]      min_sat;

    assign trial    = {rem_reg, mag_reg[VALUE_BITS-1]};
    assign qbit     = (trial >= {1'b0, radix_reg});
    assign rem_next = qbit ? DIGIT_W'(trial - {1'b0, radix_reg}) : trial[DIGIT_W-1:0];
    assign mag_next = {mag_reg[VALUE_BITS-2:0], qbit};
    assign ndig_dec = ndig_reg - CNT_W'(1);

    assign min_ext = SAT_W'(min_digits);
    assign min_sat = (min_ext > SAT_W'(VALUE_BITS)) ? CNT_W'(VALUE_BITS) : CNT_W'(min_ext);

    assign status.radix_ok      = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
    assign status.div_last      = (bit_reg == BIT_W'(VALUE_BITS - 1));
    assign status.quot_zero     = (mag_next == '0);
    assign status.neg           = neg_reg;
    assign status.pad_more      = (pad_reg > ndig_reg);
    assign status.pad_more_next = (pad_reg > ndig_reg + CNT_W'(1));
    assign status.last_digit    = (ndig_reg == CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg   <= value[VALUE_BITS-1];
            mag_reg   <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
            radix_reg <= radix;
            pad_reg   <= min_sat;
            rem_reg   <= '0;
            bit_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            mag_reg <= mag_next;
            if (status.div_last)
            begin
                stack_reg[ndig_reg[IDX_W-1:0]] <= rem_next;
                rem_reg <= '0;
                bit_reg <= '0;
            end
            else
            begin
                rem_reg <= rem_next;
                bit_reg <= bit_reg + BIT_W'(1);
            end
        end
        else if (cmd.emit_sel == EMIT_PAD)
        begin
            pad_reg <= pad_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ndig_reg <= '0;
        else if (cmd.load)
            ndig_reg <= '0;
        else if (cmd.div_step && status.div_last)
            ndig_reg <= ndig_reg + CNT_W'(1);
        else if (cmd.emit_sel == EMIT_DIGIT)
            ndig_reg <= ndig_dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= (cmd.emit_sel != EMIT_NONE);
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.emit_sel)
            EMIT_BAD:
            begin
                char_reg <= CHAR_QUESTION;
                last_reg <= 1'b1;
            end
            EMIT_SIGN:
            begin
                char_reg <= CHAR_MINUS;
                last_reg <= 1'b0;
            end
            EMIT_PAD:
            begin
                char_reg <= CHAR_ZERO;
                last_reg <= 1'b0;
            end
            EMIT_DIGIT:
            begin
                char_reg <= digit_char(stack_reg[ndig_dec[IDX_W-1:0]]);
                last_reg <= status.last_digit;
            end
            default:
            begin
                char_reg <= char_reg;
                last_reg <= last_reg;
            end
        endcase
    end

    assign char_code = char_reg;
    assign last      = last_reg;
    assign strobe    = strobe_reg;

endmodule

`default_nettype wire

// File: hw/rtl/integer_to_radix_text_unit.sv
// ----------------------------------------------------------------------------
// integer_to_radix_text_unit
// Converts a signed integer to ASCII text in radix 2 to 36.
// ----------------------------------------------------------------------------
// A request (value, radix, min_digits) is taken on a rising edge with start
// high and busy low. Characters come out on char_code, one per cycle while
// emitting, each valid for the single cycle that strobe is high; last marks
// the final character of the number. The receiver cannot stall the unit.
// A radix outside 2..36 gives one '?' character, marked last, through the
// ST_BAD state. Otherwise a bit-serial restoring divider produces the
// digits, least significant first, onto a digit stack; then the sign slot
// (a '-' for a negative value only), the pad zeros and the digits, most
// significant first, are emitted. busy drops as the last character is
// registered, so the next request may be taken in the cycle that it shows.
// Reset clears the sequencer and the strobe; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_text_unit
    import itrt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic [RADIX_W-1:0]    radix,
    input  wire logic [MIN_W-1:0]      min_digits,
    output logic [CHAR_W-1:0]          char_code,
    output logic                       last,
    output logic                       strobe
);

    cmd_t    cmd;
    status_t status;

    itrt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    itrt_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .radix      (radix),
        .min_digits (min_digits),
        .cmd        (cmd),
        .status     (status),
        .char_code  (char_code),
        .last       (last),
        .strobe     (strobe)
    );

endmodule

`default_nettype wire
